@@ hw/rtl/rss_pkg.sv @@
package rss_pkg;

    // Sample limit per set and the widths that follow from it.
    localparam int unsigned MAX_ITEMS = 65536;
    localparam int unsigned CNT_W     = 17;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned SMP_W     = 32;
    localparam int unsigned SUM_W     = 64;
    localparam int unsigned MEAN_W    = 48;
    localparam int unsigned FRAC_W    = 16;

    // The scaled quotient never reaches 2**48, so 48 restoring steps suffice.
    localparam int unsigned DIV_STEPS = 48;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MEAN,
        ST_DEV,
        ST_PEAK,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/running_sample_statistics.sv @@
// Running statistics over a set of signed 32-bit samples. Each accepted word
// gives one result word with the count, the minimum and maximum with the index
// where each was first reached, the mode (value of the longest run of equal
// consecutive samples), the mean in signed fixed point with 16 fraction bits
// truncated toward zero, and the peak absolute distance of a sample from the
// integer mean. After a word is accepted the block is not ready again until
// its result is loaded: the trackers are captured and updated on acceptance,
// the sum magnitude is formed and loaded into a single restoring
// subtract-and-compare divider that runs 48 iterations to produce the scaled
// mean, the mean is signed and the deviation peak updated, and the output register is loaded once it is free. A word
// marked last ends the set and clears the state once its result is loaded.
// After 65536 samples further samples are ignored and flagged by overflow.
module running_sample_statistics (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [rss_pkg::SMP_W-1:0]   s_sample,
    input  logic                               s_last_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic        [rss_pkg::CNT_W-1:0]   m_item_count,
    output logic signed [rss_pkg::SMP_W-1:0]   m_min_value,
    output logic        [rss_pkg::POS_W-1:0]   m_min_index,
    output logic signed [rss_pkg::SMP_W-1:0]   m_max_value,
    output logic        [rss_pkg::POS_W-1:0]   m_max_index,
    output logic signed [rss_pkg::SMP_W-1:0]   m_mode_value,
    output logic signed [rss_pkg::MEAN_W-1:0]  m_mean_fixed,
    output logic        [rss_pkg::SMP_W-1:0]   m_max_deviation,
    output logic                               m_overflow
);

    localparam int unsigned SW = rss_pkg::SMP_W;
    localparam int unsigned CW = rss_pkg::CNT_W;
    localparam int unsigned PW = rss_pkg::POS_W;
    localparam int unsigned MW = rss_pkg::MEAN_W;
    localparam int unsigned FW = rss_pkg::FRAC_W;
    localparam int unsigned UW = rss_pkg::SUM_W;
    localparam int unsigned TW = rss_pkg::STEP_W;

    rss_pkg::state_t state_reg, state_next;

    // Control strobes from the output decode.
    logic accept;
    logic out_load;

    // Captured word.
    logic [SW-1:0] sample_reg;
    logic          last_reg;
    logic          ovf_reg;

    // Set statistics.
    logic [UW-1:0] sum_reg;
    logic [CW-1:0] count_reg;
    logic [SW-1:0] min_reg;
    logic [PW-1:0] min_pos_reg;
    logic [SW-1:0] max_reg;
    logic [PW-1:0] max_pos_reg;
    logic [SW-1:0] mode_reg;
    logic [SW-1:0] tie_reg;
    logic [SW-1:0] prev_reg;
    logic [CW-1:0] cur_run_reg;
    logic [CW-1:0] best_run_reg;
    logic [SW-1:0] peak_reg;

    // Divider and mean datapath.
    logic          neg_reg;
    logic [MW-1:0] quo_reg;
    logic [CW-1:0] rem_reg;
    logic [TW-1:0] step_reg;
    logic [MW-1:0] mean_reg;
    logic [SW:0]   imean_reg;
    logic [SW+1:0] diff_reg;

    // Output register.
    logic          m_valid_reg;
    logic [CW-1:0] o_count_reg;
    logic [SW-1:0] o_min_reg;
    logic [PW-1:0] o_min_pos_reg;
    logic [SW-1:0] o_max_reg;
    logic [PW-1:0] o_max_pos_reg;
    logic [SW-1:0] o_mode_reg;
    logic [MW-1:0] o_mean_reg;
    logic [SW-1:0] o_peak_reg;
    logic          o_ovf_reg;

    // Combinational helpers.
    logic          full;
    logic          s_gt_max;
    logic          s_lt_min;
    logic [CW-1:0] run_next;
    logic          take_mode;
    logic [UW-1:0] sum_mag;
    logic [CW:0]   trial;
    logic          fits;
    logic [SW:0]   imean_mag;
    logic [SW+1:0] diff_abs;
    logic          step_last;

    assign full      = (count_reg >= CW'(rss_pkg::MAX_ITEMS));
    assign s_gt_max  = ($signed(s_sample) > $signed(max_reg));
    assign s_lt_min  = ($signed(s_sample) < $signed(min_reg));
    assign run_next  = (s_sample == prev_reg) ? cur_run_reg + CW'(1) : CW'(1);
    assign take_mode = (run_next > best_run_reg)
                    || ((run_next == best_run_reg) && ($signed(s_sample) > $signed(tie_reg)));
    assign sum_mag   = sum_reg[UW-1] ? (~sum_reg + UW'(1)) : sum_reg;
    assign trial     = {rem_reg, quo_reg[MW-1]};
    assign fits      = (trial >= {1'b0, count_reg});
    assign imean_mag = {1'b0, quo_reg[MW-1:FW]};
    assign diff_abs  = diff_reg[SW+1] ? (~diff_reg + (SW+2)'(1)) : diff_reg;
    assign step_last = (step_reg == TW'(0));

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rss_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rss_pkg::ST_PREP;
                end
            end
            rss_pkg::ST_PREP: state_next = rss_pkg::ST_DIV;
            rss_pkg::ST_DIV: begin
                if (step_last) begin
                    state_next = rss_pkg::ST_MEAN;
                end
            end
            rss_pkg::ST_MEAN: state_next = rss_pkg::ST_DEV;
            rss_pkg::ST_DEV:  state_next = rss_pkg::ST_PEAK;
            rss_pkg::ST_PEAK: state_next = rss_pkg::ST_DONE;
            rss_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = rss_pkg::ST_IDLE;
                end
            end
            default: state_next = rss_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            rss_pkg::ST_IDLE: s_ready  = 1'b1;
            rss_pkg::ST_DONE: out_load = !m_valid_reg || m_ready;
            default: begin
                s_ready  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Statistics update on acceptance, clear after a last word is delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn || (out_load && last_reg)) begin
            sum_reg      <= '0;
            count_reg    <= '0;
            min_reg      <= '0;
            min_pos_reg  <= '0;
            max_reg      <= '0;
            max_pos_reg  <= '0;
            mode_reg     <= '0;
            tie_reg      <= '0;
            prev_reg     <= '0;
            cur_run_reg  <= '0;
            best_run_reg <= '0;
            peak_reg     <= '0;
        end else if (accept && !full) begin
            if (count_reg == '0) begin
                sum_reg      <= {{(UW-SW){s_sample[SW-1]}}, s_sample};
                count_reg    <= CW'(1);
                min_reg      <= s_sample;
                min_pos_reg  <= '0;
                max_reg      <= s_sample;
                max_pos_reg  <= '0;
                mode_reg     <= s_sample;
                tie_reg      <= s_sample;
                prev_reg     <= s_sample;
                cur_run_reg  <= CW'(1);
                best_run_reg <= CW'(1);
                peak_reg     <= '0;
            end else begin
                if (s_gt_max) begin
                    max_reg     <= s_sample;
                    max_pos_reg <= count_reg[PW-1:0];
                end else if (s_lt_min) begin
                    min_reg     <= s_sample;
                    min_pos_reg <= count_reg[PW-1:0];
                end
                sum_reg     <= sum_reg + {{(UW-SW){s_sample[SW-1]}}, s_sample};
                count_reg   <= count_reg + CW'(1);
                cur_run_reg <= run_next;
                prev_reg    <= s_sample;
                if (take_mode) begin
                    best_run_reg <= run_next;
                    mode_reg     <= s_sample;
                    tie_reg      <= s_sample;
                end
            end
        end else if (state_reg == rss_pkg::ST_PEAK && !ovf_reg
                     && (diff_abs[SW-1:0] > peak_reg)) begin
            // The distance always fits in 32 bits since the integer mean lies within the sample range.
            peak_reg <= diff_abs[SW-1:0];
        end
    end

    // Word capture and the shared divider datapath.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
            last_reg   <= s_last_item;
            ovf_reg    <= full;
        end
        case (state_reg)
            rss_pkg::ST_PREP: begin
                // Dividend is |sum| * 2**16; its top 16 bits are already below the count.
                neg_reg  <= sum_reg[UW-1];
                rem_reg  <= {1'b0, sum_mag[MW-1:SW]};
                quo_reg  <= {sum_mag[SW-1:0], {FW{1'b0}}};
                step_reg <= TW'(rss_pkg::DIV_STEPS - 1);
            end
            rss_pkg::ST_DIV: begin
                if (fits) begin
                    rem_reg <= CW'(trial - {1'b0, count_reg});
                end else begin
                    rem_reg <= trial[CW-1:0];
                end
                quo_reg  <= {quo_reg[MW-2:0], fits};
                step_reg <= step_reg - TW'(1);
            end
            rss_pkg::ST_MEAN: begin
                mean_reg  <= neg_reg ? (~quo_reg + MW'(1)) : quo_reg;
                imean_reg <= neg_reg ? (~imean_mag + (SW+1)'(1)) : imean_mag;
            end
            rss_pkg::ST_DEV: begin
                diff_reg <= {{2{sample_reg[SW-1]}}, sample_reg} - {imean_reg[SW], imean_reg};
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_count_reg   <= count_reg;
            o_min_reg     <= min_reg;
            o_min_pos_reg <= min_pos_reg;
            o_max_reg     <= max_reg;
            o_max_pos_reg <= max_pos_reg;
            o_mode_reg    <= mode_reg;
            o_mean_reg    <= mean_reg;
            o_peak_reg    <= peak_reg;
            o_ovf_reg     <= ovf_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_item_count    = o_count_reg;
    assign m_min_value     = $signed(o_min_reg);
    assign m_min_index     = o_min_pos_reg;
    assign m_max_value     = $signed(o_max_reg);
    assign m_max_index     = o_max_pos_reg;
    assign m_mode_value    = $signed(o_mode_reg);
    assign m_mean_fixed    = $signed(o_mean_reg);
    assign m_max_deviation = o_peak_reg;
    assign m_overflow      = o_ovf_reg;

    // The divider remainder stays below the divisor on every iteration.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rss_pkg::ST_DIV) |-> (rem_reg < count_reg))
        else $error("divider remainder not below the count");

    // The count never passes the set limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(rss_pkg::MAX_ITEMS))
        else $error("sample count above limit");

    // A result is loaded only from the final sequencer state.
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == rss_pkg::ST_DONE))
        else $error("result loaded outside the done state");

    // An ignored sample is reported only when the set is full.
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && o_ovf_reg) |-> (o_count_reg == CW'(rss_pkg::MAX_ITEMS)))
        else $error("overflow flagged below the limit");

    // An accepted word always leaves the divider loaded with a full step count.
    a_prep_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rss_pkg::ST_PREP)
            |=> (state_reg == rss_pkg::ST_DIV
                 && step_reg == TW'(rss_pkg::DIV_STEPS - 1)))
        else $error("divider not started correctly");

endmodule
